### rtl/core/lgcs_pkg.sv
// Shared types and constants for the line grid crossing stepper.
// Holds the request and response payloads and the register index codes.
// No dependencies.
package lgcs_pkg;

   localparam int COORD_W    = 32;
   localparam int TIME_W     = 32;
   localparam int TIME_FRAC  = 28;
   localparam int SUM_W      = 64;
   localparam int LEN_W      = SUM_W / 2;
   localparam int SQRT_STEPS = SUM_W / 2;
   localparam int CSR_IDX_W  = 3;

   localparam logic [31:0] SPEED_RESET = 32'd6553600;

   // Register index codes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_START_X = 3'd0,
      CSR_START_Y = 3'd1,
      CSR_END_X   = 3'd2,
      CSR_END_Y   = 3'd3,
      CSR_SPEED   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] cur_x;
      logic signed [COORD_W-1:0] cur_y;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] next_x;
      logic signed [COORD_W-1:0] next_y;
      logic        [TIME_W-1:0]  step_time;
      logic                      time_overflow;
      logic                      at_end;
   } rsp_type;

endpackage

### rtl/core/line_grid_crossing_stepper.sv
// Top level of the line grid crossing stepper: configuration, step pipeline.
// Depends on lgcs_pkg, lgcs_div and lgcs_sqrt.
//
//   Channel   Direction   Ports                              Payload
//   request   in          req_valid, req_stall, req_data     cur_x, cur_y
//   response  out         rsp_valid, rsp_stall, rsp_data     next point, time, flags
//   csr       in          csr_wen, csr_index, csr_wdata      start, end, speed
//
// One request enters per cycle unless the response is stalled; each gives one response.
// Most of the pipeline's depth lies in the bit-per-stage minor-step divider,
// shortening divider, square root and time divider.
// Reset is synchronous; it clears the valid bits and the start and end registers and sets speed to SPEED_RESET.
// A stalled response freezes the whole pipeline; nothing is dropped or repeated.
module line_grid_crossing_stepper #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  lgcs_pkg::req_type    req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output lgcs_pkg::rsp_type    rsp_data,
   input  logic                 csr_wen,
   input  logic [lgcs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   import lgcs_pkg::*;

   localparam int SMW = FRAC_BITS + 2;
   localparam int NMW = FRAC_BITS + 3;
   localparam int P1W = FRAC_BITS + 35;
   localparam int DW1 = 33;
   localparam int QW1 = FRAC_BITS + 1;
   localparam int P2W = 2 * FRAC_BITS + 5;
   localparam int DW2 = FRAC_BITS + 1;
   localparam int QW2 = 2 * FRAC_BITS + 3;
   localparam int SFW = 2 * FRAC_BITS + 4;
   localparam int MMW = QW2;
   localparam int MNW = FRAC_BITS + 2;
   localparam int SQW = 2 * MMW;
   localparam int SNW = 2 * MNW;
   localparam int OVF_SHIFT = TIME_W - TIME_FRAC;

   localparam logic signed [33:0] FX_ONE  = 34'sd1 <<< FRAC_BITS;
   localparam logic signed [33:0] FX_MASK = FX_ONE - 34'sd1;

   typedef struct packed {
      logic signed [31:0]    cur_x;
      logic signed [31:0]    cur_y;
      logic signed [31:0]    c_maj;
      logic signed [31:0]    c_min;
      logic signed [31:0]    n_maj;
      logic signed [31:0]    n_min;
      logic signed [33:0]    tc_min;
      logic signed [SMW-1:0] s_maj;
      logic signed [SMW-1:0] s_min;
      logic signed [NMW-1:0] new_min;
      logic                  crossed;
      logic                  sgn;
      logic                  ovf;
      logic                  at_end;
   } trk_type;

   localparam int TW = $bits(trk_type);

   // Truncation toward zero to a whole number, kept in fixed point.
   function automatic logic signed [33:0] fx_trunc(input logic signed [33:0] v);
      logic signed [33:0] base;
      base = v & ~FX_MASK;
      if (v < 0 && (v & FX_MASK) != 0) base = base + FX_ONE;
      return base;
   endfunction

   logic adv;
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // Configuration registers.
   logic signed [31:0] start_x_ff, start_y_ff, end_x_ff, end_y_ff;
   logic        [31:0] speed_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         end_x_ff   <= '0;
         end_y_ff   <= '0;
         speed_ff   <= SPEED_RESET;
      end else if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_X: start_x_ff <= csr_wdata;
            CSR_START_Y: start_y_ff <= csr_wdata;
            CSR_END_X:   end_x_ff   <= csr_wdata;
            CSR_END_Y:   end_y_ff   <= csr_wdata;
            CSR_SPEED:   speed_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Segment values derived from configuration, first level.
   logic signed [32:0] dx_ff, dy_ff;
   logic signed [33:0] tend_x_ff, tend_y_ff;
   logic               speed_nz_ff;

   always_ff @(posedge clock) begin
      dx_ff       <= 33'(end_x_ff) - 33'(start_x_ff);
      dy_ff       <= 33'(end_y_ff) - 33'(start_y_ff);
      tend_x_ff   <= fx_trunc(34'(end_x_ff));
      tend_y_ff   <= fx_trunc(34'(end_y_ff));
      speed_nz_ff <= speed_ff != '0;
   end

   // Second level: major axis choice and whether the segment moves at all.
   logic        [32:0] adx_in, ady_in;
   logic               y_major_in;
   logic               y_major_ff, active_ff;
   logic signed [32:0] d_maj_ff, d_min_ff;

   assign adx_in     = dx_ff < 0 ? -dx_ff : dx_ff;
   assign ady_in     = dy_ff < 0 ? -dy_ff : dy_ff;
   assign y_major_in = ady_in > adx_in;

   always_ff @(posedge clock) begin
      y_major_ff <= y_major_in;
      d_maj_ff   <= y_major_in ? dy_ff : dx_ff;
      d_min_ff   <= y_major_in ? dx_ff : dy_ff;
      active_ff  <= speed_nz_ff && !(dx_ff < 33'(FX_ONE) && dy_ff < 33'(FX_ONE));
   end

   // Stage A: request register.
   logic    a_valid_ff;
   req_type a_req_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         a_req_ff   <= req_data;
      end
   end

   // Stage B: step to the next whole number on both axes.
   logic signed [33:0]    cx_w, cy_w;
   logic                  b_valid_ff;
   logic signed [31:0]    b_cx_ff, b_cy_ff;
   logic signed [SMW-1:0] b_sx_ff, b_sy_ff;
   logic signed [33:0]    b_tcx_ff, b_tcy_ff;
   logic signed [33:0]    sx_in, sy_in;

   assign cx_w  = 34'(a_req_ff.cur_x);
   assign cy_w  = 34'(a_req_ff.cur_y);
   assign sx_in = fx_trunc(cx_w + FX_ONE) - cx_w;
   assign sy_in = fx_trunc(cy_w + FX_ONE) - cy_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (adv) begin
         b_valid_ff <= a_valid_ff;
         b_cx_ff    <= a_req_ff.cur_x;
         b_cy_ff    <= a_req_ff.cur_y;
         b_sx_ff    <= sx_in[SMW-1:0];
         b_sy_ff    <= sy_in[SMW-1:0];
         b_tcx_ff   <= fx_trunc(cx_w);
         b_tcy_ff   <= fx_trunc(cy_w);
      end
   end

   // Stage C: pick the major axis and form the minor-step numerator.
   trk_type               c_trk_in, c_trk_ff;
   logic                  c_valid_ff;
   logic signed [P1W-1:0] c_prod_ff, c_prod_in;

   always_comb begin
      c_trk_in         = '0;
      c_trk_in.cur_x   = b_cx_ff;
      c_trk_in.cur_y   = b_cy_ff;
      c_trk_in.c_maj   = y_major_ff ? b_cy_ff : b_cx_ff;
      c_trk_in.c_min   = y_major_ff ? b_cx_ff : b_cy_ff;
      c_trk_in.tc_min  = y_major_ff ? b_tcx_ff : b_tcy_ff;
      c_trk_in.s_maj   = y_major_ff ? b_sy_ff : b_sx_ff;
      c_trk_in.at_end  = (b_tcx_ff == tend_x_ff) && (b_tcy_ff == tend_y_ff);
   end

   assign c_prod_in = P1W'(d_min_ff) * P1W'(c_trk_in.s_maj);

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (adv) begin
         c_valid_ff <= b_valid_ff;
         c_trk_ff   <= c_trk_in;
         c_prod_ff  <= c_prod_in;
      end
   end

   // Stage D: magnitudes and quotient sign for the minor-step divide.
   trk_type              d_trk_in, d_trk_ff;
   logic                 d_valid_ff;
   logic [DW1+QW1-1:0]   d_num_ff;
   logic [DW1-1:0]       d_den_ff;
   logic signed [P1W-1:0] d_mag_in;

   assign d_mag_in = c_prod_ff < 0 ? -c_prod_ff : c_prod_ff;

   always_comb begin
      d_trk_in     = c_trk_ff;
      d_trk_in.sgn = c_prod_ff[P1W-1] ^ d_maj_ff[32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else if (adv) begin
         d_valid_ff <= c_valid_ff;
         d_trk_ff   <= d_trk_in;
         d_num_ff   <= d_mag_in[DW1+QW1-1:0];
         d_den_ff   <= d_maj_ff < 0 ? -d_maj_ff : d_maj_ff;
      end
   end

   logic           q1_valid;
   logic [QW1-1:0] q1_quo;
   logic [TW-1:0]  q1_side;

   lgcs_div #(.DW(DW1), .QW(QW1), .SW(TW)) u_div_min (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (d_valid_ff),
      .in_num    (d_num_ff),
      .in_den    (d_den_ff),
      .in_side   (d_trk_ff),
      .out_valid (q1_valid),
      .out_quo   (q1_quo),
      .out_side  (q1_side)
   );

   // Stage E1: signed minor step and the minor coordinate it reaches.
   trk_type               e1_trk_in, e1_trk_ff;
   logic                  e1_valid_ff;
   logic signed [33:0]    e1_nm_ff;
   logic signed [SMW-1:0] qs1_w;

   assign qs1_w = SMW'(q1_quo);

   always_comb begin
      e1_trk_in       = trk_type'(q1_side);
      e1_trk_in.s_min = e1_trk_in.sgn ? -qs1_w : qs1_w;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= q1_valid;
         e1_trk_ff   <= e1_trk_in;
         e1_nm_ff    <= 34'(e1_trk_in.c_min) + 34'(e1_trk_in.s_min);
      end
   end

   // Stage E2: does the minor coordinate cross a grid line first?
   trk_type            e2_trk_in, e2_trk_ff;
   logic               e2_valid_ff;
   logic signed [33:0] tnm_w, nmd_w;

   assign tnm_w = fx_trunc(e1_nm_ff);
   assign nmd_w = tnm_w - 34'(e1_trk_ff.c_min);

   always_comb begin
      e2_trk_in         = e1_trk_ff;
      e2_trk_in.crossed = tnm_w != e1_trk_ff.tc_min;
      e2_trk_in.new_min = nmd_w[NMW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e2_valid_ff <= e1_valid_ff;
         e2_trk_ff   <= e2_trk_in;
      end
   end

   // Stage F: numerator of the shortened major step.
   trk_type               f_trk_ff;
   logic                  f_valid_ff;
   logic signed [P2W-1:0] f_prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (adv) begin
         f_valid_ff <= e2_valid_ff;
         f_trk_ff   <= e2_trk_ff;
         f_prod_ff  <= P2W'(e2_trk_ff.s_maj) * P2W'(e2_trk_ff.new_min);
      end
   end

   // Stage G: magnitudes and quotient sign for the shortening divide.
   trk_type               g_trk_in, g_trk_ff;
   logic                  g_valid_ff;
   logic [DW2+QW2-1:0]    g_num_ff;
   logic [DW2-1:0]        g_den_ff;
   logic signed [P2W-1:0] g_mag_w;
   logic signed [SMW-1:0] g_dmag_w;

   assign g_mag_w  = f_prod_ff < 0 ? -f_prod_ff : f_prod_ff;
   assign g_dmag_w = f_trk_ff.s_min < 0 ? -f_trk_ff.s_min : f_trk_ff.s_min;

   always_comb begin
      g_trk_in     = f_trk_ff;
      g_trk_in.sgn = f_prod_ff[P2W-1] ^ f_trk_ff.s_min[SMW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff <= 1'b0;
      end else if (adv) begin
         g_valid_ff <= f_valid_ff;
         g_trk_ff   <= g_trk_in;
         g_num_ff   <= (DW2+QW2)'(g_mag_w);
         g_den_ff   <= g_dmag_w[DW2-1:0];
      end
   end

   logic           q2_valid;
   logic [QW2-1:0] q2_quo;
   logic [TW-1:0]  q2_side;

   lgcs_div #(.DW(DW2), .QW(QW2), .SW(TW)) u_div_maj (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (g_valid_ff),
      .in_num    (g_num_ff),
      .in_den    (g_den_ff),
      .in_side   (g_trk_ff),
      .out_valid (q2_valid),
      .out_quo   (q2_quo),
      .out_side  (q2_side)
   );

   // Stage H1: final steps on both axes and their magnitudes.
   trk_type               h1_trk_w, h1_trk_ff;
   logic                  h1_valid_ff;
   logic                  use2_w;
   logic signed [SFW-1:0] qs2_w, smaj_in;
   logic signed [NMW-1:0] smin_in;
   logic [MMW-1:0]        magmaj_in;
   logic signed [NMW-1:0] sminabs_w;
   logic signed [SFW-1:0] h1_smaj_ff;
   logic signed [NMW-1:0] h1_smin_ff;
   logic [MMW-1:0]        h1_magmaj_ff;
   logic [MNW-1:0]        h1_magmin_ff;

   assign h1_trk_w  = trk_type'(q2_side);
   assign use2_w    = h1_trk_w.crossed && (h1_trk_w.s_min != '0);
   assign qs2_w     = SFW'(q2_quo);
   assign smaj_in   = use2_w ? (h1_trk_w.sgn ? -qs2_w : qs2_w) : SFW'(h1_trk_w.s_maj);
   assign magmaj_in = use2_w ? q2_quo : MMW'(h1_trk_w.s_maj);
   assign smin_in   = h1_trk_w.crossed ? h1_trk_w.new_min : NMW'(h1_trk_w.s_min);
   assign sminabs_w = smin_in < 0 ? -smin_in : smin_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         h1_valid_ff <= 1'b0;
      end else if (adv) begin
         h1_valid_ff  <= q2_valid;
         h1_trk_ff    <= h1_trk_w;
         h1_smaj_ff   <= smaj_in;
         h1_smin_ff   <= smin_in;
         h1_magmaj_ff <= magmaj_in;
         h1_magmin_ff <= sminabs_w[MNW-1:0];
      end
   end

   // Stage H2: next point and the squared step lengths.
   trk_type          h2_trk_in, h2_trk_ff;
   logic             h2_valid_ff;
   logic [SQW-1:0]   sqmaj_w;
   logic [SNW-1:0]   sqmin_w;
   logic [SUM_W-1:0] h2_sqmaj_ff, h2_sqmin_ff;

   assign sqmaj_w = SQW'(h1_magmaj_ff) * SQW'(h1_magmaj_ff);
   assign sqmin_w = SNW'(h1_magmin_ff) * SNW'(h1_magmin_ff);

   always_comb begin
      h2_trk_in       = h1_trk_ff;
      h2_trk_in.n_maj = h1_trk_ff.c_maj + 32'(h1_smaj_ff);
      h2_trk_in.n_min = h1_trk_ff.c_min + 32'(h1_smin_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h2_valid_ff <= 1'b0;
      end else if (adv) begin
         h2_valid_ff <= h1_valid_ff;
         h2_trk_ff   <= h2_trk_in;
         h2_sqmaj_ff <= SUM_W'(sqmaj_w);
         h2_sqmin_ff <= SUM_W'(sqmin_w);
      end
   end

   // Stage I: sum of squares, wrapping at 64 bits.
   trk_type          i_trk_ff;
   logic             i_valid_ff;
   logic [SUM_W-1:0] i_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_valid_ff <= 1'b0;
      end else if (adv) begin
         i_valid_ff <= h2_valid_ff;
         i_trk_ff   <= h2_trk_ff;
         i_sum_ff   <= h2_sqmaj_ff + h2_sqmin_ff;
      end
   end

   logic             sq_valid;
   logic [LEN_W-1:0] sq_len;
   logic [TW-1:0]    sq_side;

   lgcs_sqrt #(.SW(TW)) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (i_valid_ff),
      .in_sum    (i_sum_ff),
      .in_side   (i_trk_ff),
      .out_valid (sq_valid),
      .out_len   (sq_len),
      .out_side  (sq_side)
   );

   // Stage K: time overflow check and the time-divide numerator.
   trk_type          k_trk_in, k_trk_ff;
   logic             k_valid_ff;
   logic [SUM_W-1:0] k_num_ff;

   always_comb begin
      k_trk_in     = trk_type'(sq_side);
      k_trk_in.ovf = 32'(sq_len >> OVF_SHIFT) >= speed_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_valid_ff <= 1'b0;
      end else if (adv) begin
         k_valid_ff <= sq_valid;
         k_trk_ff   <= k_trk_in;
         k_num_ff   <= SUM_W'(sq_len) << TIME_FRAC;
      end
   end

   logic              q3_valid;
   logic [TIME_W-1:0] q3_quo;
   logic [TW-1:0]     q3_side;

   lgcs_div #(.DW(TIME_W), .QW(TIME_W), .SW(TW)) u_div_time (
      .clock     (clock),
      .reset     (reset),
      .enable    (adv),
      .in_valid  (k_valid_ff),
      .in_num    (k_num_ff),
      .in_den    (speed_ff),
      .in_side   (k_trk_ff),
      .out_valid (q3_valid),
      .out_quo   (q3_quo),
      .out_side  (q3_side)
   );

   // Stage L: response register, mapped back to x and y.
   trk_type l_trk_w;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign l_trk_w = trk_type'(q3_side);

   always_comb begin
      rsp_in.at_end = l_trk_w.at_end;
      if (active_ff) begin
         rsp_in.next_x        = y_major_ff ? l_trk_w.n_min : l_trk_w.n_maj;
         rsp_in.next_y        = y_major_ff ? l_trk_w.n_maj : l_trk_w.n_min;
         rsp_in.step_time     = l_trk_w.ovf ? '1 : q3_quo;
         rsp_in.time_overflow = l_trk_w.ovf;
      end else begin
         rsp_in.next_x        = l_trk_w.cur_x;
         rsp_in.next_y        = l_trk_w.cur_y;
         rsp_in.step_time     = '0;
         rsp_in.time_overflow = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= q3_valid;
         rsp_data_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/core/lgcs_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Stand-alone; no package dependencies.
module lgcs_div #(
   parameter int DW = 33,
   parameter int QW = 17,
   parameter int SW = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic [DW+QW-1:0] in_num,
   input  logic [DW-1:0]    in_den,
   input  logic [SW-1:0]    in_side,
   output logic             out_valid,
   output logic [QW-1:0]    out_quo,
   output logic [SW-1:0]    out_side
);

   localparam int RW = DW + QW;

   logic          vld_ff  [QW];
   logic [RW-1:0] rem_ff  [QW];
   logic [DW-1:0] den_ff  [QW];
   logic [QW-1:0] quo_ff  [QW];
   logic [SW-1:0] side_ff [QW];

   // Each stage tries the divisor shifted to its own quotient bit.
   for (genvar s = 0; s < QW; s++) begin : g_stage
      logic          pv;
      logic [RW-1:0] prem;
      logic [DW-1:0] pden;
      logic [QW-1:0] pquo;
      logic [SW-1:0] pside;
      logic [RW-1:0] trial;
      logic          take;
      logic [RW-1:0] rem_in;
      logic [QW-1:0] quo_in;

      if (s == 0) begin : g_first
         assign pv    = in_valid;
         assign prem  = in_num;
         assign pden  = in_den;
         assign pquo  = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = vld_ff[s-1];
         assign prem  = rem_ff[s-1];
         assign pden  = den_ff[s-1];
         assign pquo  = quo_ff[s-1];
         assign pside = side_ff[s-1];
      end

      assign trial  = RW'(pden) << (QW - 1 - s);
      assign take   = prem >= trial;
      assign rem_in = take ? prem - trial : prem;
      assign quo_in = take ? (pquo | (QW'(1) << (QW - 1 - s))) : pquo;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s] <= 1'b0;
         end else if (enable) begin
            vld_ff[s]  <= pv;
            rem_ff[s]  <= rem_in;
            den_ff[s]  <= pden;
            quo_ff[s]  <= quo_in;
            side_ff[s] <= pside;
         end
      end
   end

   assign out_valid = vld_ff[QW-1];
   assign out_quo   = quo_ff[QW-1];
   assign out_side  = side_ff[QW-1];

endmodule

### rtl/core/lgcs_sqrt.sv
// Pipelined floor square root of a 64-bit sum, one result bit per stage.
// Depends on lgcs_pkg for the word widths.
module lgcs_sqrt #(
   parameter int SW = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  logic                     in_valid,
   input  logic [lgcs_pkg::SUM_W-1:0] in_sum,
   input  logic [SW-1:0]            in_side,
   output logic                     out_valid,
   output logic [lgcs_pkg::LEN_W-1:0] out_len,
   output logic [SW-1:0]            out_side
);

   import lgcs_pkg::*;

   logic             vld_ff  [SQRT_STEPS];
   logic [SUM_W-1:0] n_ff    [SQRT_STEPS];
   logic [SUM_W-1:0] res_ff  [SQRT_STEPS];
   logic [SW-1:0]    side_ff [SQRT_STEPS];

   // Digit-by-digit root: each stage settles one bit of the result.
   for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_stage
      logic             pv;
      logic [SUM_W-1:0] pn;
      logic [SUM_W-1:0] pres;
      logic [SW-1:0]    pside;
      logic [SUM_W-1:0] bitv;
      logic [SUM_W-1:0] trial;
      logic             take;
      logic [SUM_W-1:0] n_in;
      logic [SUM_W-1:0] res_in;

      if (j == 0) begin : g_first
         assign pv    = in_valid;
         assign pn    = in_sum;
         assign pres  = '0;
         assign pside = in_side;
      end else begin : g_next
         assign pv    = vld_ff[j-1];
         assign pn    = n_ff[j-1];
         assign pres  = res_ff[j-1];
         assign pside = side_ff[j-1];
      end

      assign bitv   = SUM_W'(1) << (SUM_W - 2 - 2 * j);
      assign trial  = pres + bitv;
      assign take   = pn >= trial;
      assign n_in   = take ? pn - trial : pn;
      assign res_in = take ? (pres >> 1) + bitv : pres >> 1;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (enable) begin
            vld_ff[j]  <= pv;
            n_ff[j]    <= n_in;
            res_ff[j]  <= res_in;
            side_ff[j] <= pside;
         end
      end
   end

   assign out_valid = vld_ff[SQRT_STEPS-1];
   assign out_len   = res_ff[SQRT_STEPS-1][LEN_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

### sim/line_grid_crossing_stepper_test.sv
// Self-checking testbench for the line grid crossing stepper.
// Depends on lgcs_pkg and line_grid_crossing_stepper; predicts each response in place.
module line_grid_crossing_stepper_test;
   import lgcs_pkg::*;

   localparam int       FRAC       = 16;
   localparam longint   FX_ONE     = 64'sd1 <<< FRAC;
   localparam int       LATENCY    = 3 * FRAC + 81;
   localparam int       CYCLE_MAX  = 600000;
   localparam int       RAND_ITEMS = 1950;
   localparam int       PHASE_ITEMS = 150;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd5;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   // Copy of the configuration registers used by the predictor.
   logic signed [31:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
   logic        [31:0] move_speed;

   rsp_type     pending_steps[$];
   int          mismatch_count = 0;
   int          steps_sent = 0;
   int          steps_checked = 0;
   int          overflow_seen = 0;
   int          arrival_seen = 0;
   int          cycle_count = 0;
   int          burst_left;
   bit          driving = 0;

   line_grid_crossing_stepper DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wen(csr_wen), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Run limit, far beyond the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_MAX) begin
         $display("line_grid_crossing_stepper_test: done, errors");
         $finish;
      end
   end

   function automatic longint fx_trunc(longint v);
      return v - (v % FX_ONE);
   endfunction

   function automatic longint fx_int(longint v);
      return v / FX_ONE;
   endfunction

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Floor square root, one result bit per pair of input bits.
   function automatic longint unsigned floor_sqrt(longint unsigned n);
      longint unsigned res = 0;
      longint unsigned b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   // Advance the major axis to the next integer, shortened at a minor crossing.
   function automatic void grid_step(input longint c_maj, input longint c_min,
                                     input longint d_maj, input longint d_min,
                                     output longint n_maj, output longint n_min,
                                     output logic [31:0] tm, output logic ovf);
      longint s_maj, s_min, nm, new_min;
      longint unsigned sum, len, t;
      s_maj = fx_trunc(c_maj + FX_ONE) - c_maj;
      s_min = (d_maj != 0) ? (d_min * s_maj) / d_maj : 0;
      nm = c_min + s_min;
      if (fx_int(c_min) != fx_int(nm)) begin
         new_min = fx_trunc(nm) - c_min;
         if (s_min != 0) s_maj = (s_maj * new_min) / s_min;
         s_min = new_min;
      end
      n_maj = c_maj + s_maj;
      n_min = c_min + s_min;
      sum = longint'(s_maj * s_maj) + longint'(s_min * s_min);
      len = floor_sqrt(sum);
      t = (len << TIME_FRAC) / longint'({32'd0, move_speed});
      if (t > 64'hFFFF_FFFF) begin
         tm = 32'hFFFF_FFFF;
         ovf = 1'b1;
      end else begin
         tm = t[31:0];
         ovf = 1'b0;
      end
   endfunction

   function automatic rsp_type predict_crossing(req_type r);
      longint cx, cy, dx, dy, nx, ny;
      logic [31:0] tm;
      logic ovf;
      rsp_type p;
      cx = r.cur_x;
      cy = r.cur_y;
      dx = longint'(seg_end_x) - longint'(seg_start_x);
      dy = longint'(seg_end_y) - longint'(seg_start_y);
      nx = cx;
      ny = cy;
      tm = '0;
      ovf = 1'b0;
      if (move_speed != 0 && !(dx < FX_ONE && dy < FX_ONE)) begin
         if (abs64(dy) > abs64(dx)) grid_step(cy, cx, dy, dx, ny, nx, tm, ovf);
         else grid_step(cx, cy, dx, dy, nx, ny, tm, ovf);
      end
      p.next_x = nx[31:0];
      p.next_y = ny[31:0];
      p.step_time = tm;
      p.time_overflow = ovf;
      p.at_end = (fx_int(cx) == fx_int(longint'(seg_end_x))) &&
                 (fx_int(cy) == fx_int(longint'(seg_end_y)));
      return p;
   endfunction

   // Receiver stall pattern: stretches of no stall, light stall and heavy stall.
   int stall_window = 0;
   int stall_pct = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_window == 0) begin
            stall_window = $urandom_range(20, 200);
            case ($urandom_range(2))
               0: stall_pct = 0;
               1: stall_pct = 25;
               default: stall_pct = 75;
            endcase
         end
         stall_window--;
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Response checker against the oldest pending prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_steps.size() == 0) begin
            $error("response with no request outstanding: %h", rsp_data);
            mismatch_count++;
         end else begin
            want = pending_steps.pop_front();
            steps_checked++;
            if (rsp_data.time_overflow) overflow_seen++;
            if (rsp_data.at_end) arrival_seen++;
            if (rsp_data.next_x !== want.next_x) begin
               $error("next_x: expected %h, got %h", want.next_x, rsp_data.next_x);
               mismatch_count++;
            end
            if (rsp_data.next_y !== want.next_y) begin
               $error("next_y: expected %h, got %h", want.next_y, rsp_data.next_y);
               mismatch_count++;
            end
            if (rsp_data.step_time !== want.step_time) begin
               $error("step_time: expected %h, got %h", want.step_time,
                      rsp_data.step_time);
               mismatch_count++;
            end
            if (rsp_data.time_overflow !== want.time_overflow) begin
               $error("time_overflow: expected %b, got %b", want.time_overflow,
                      rsp_data.time_overflow);
               mismatch_count++;
            end
            if (rsp_data.at_end !== want.at_end) begin
               $error("at_end: expected %b, got %b", want.at_end, rsp_data.at_end);
               mismatch_count++;
            end
         end
      end
   end

   // Register write; the block is idle whenever this is called.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      case (idx)
         CSR_START_X: seg_start_x = value;
         CSR_START_Y: seg_start_y = value;
         CSR_END_X:   seg_end_x = value;
         CSR_END_Y:   seg_end_y = value;
         CSR_SPEED:   move_speed = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_segment(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                              logic [31:0] ey, logic [31:0] spd);
      write_csr(CSR_START_X, sx);
      write_csr(CSR_START_Y, sy);
      write_csr(CSR_END_X, ex);
      write_csr(CSR_END_Y, ey);
      write_csr(CSR_SPEED, spd);
   endtask

   // Send one request; bursts end with a random gap.
   task automatic send_position(logic [31:0] x, logic [31:0] y);
      req_type r;
      r.cur_x = x;
      r.cur_y = y;
      req_valid <= 1'b1;
      req_data <= r;
      driving = 1;
      do @(posedge clock); while (req_stall);
      pending_steps.push_back(predict_crossing(r));
      steps_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         req_valid <= 1'b0;
         driving = 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 60);
      end
   endtask

   // Drop valid and wait for every pending response.
   task automatic drain_steps();
      if (driving) begin
         req_valid <= 1'b0;
         driving = 0;
         @(posedge clock);
      end
      while (pending_steps.size() != 0) @(posedge clock);
   endtask

   // Reset registers describe a zero-length segment: every point stays put.
   task automatic test_reset_segment();
      send_position(32'h0000_0000, 32'h0000_0000);
      send_position(32'h7FFF_FFFF, 32'h8000_0000);
      send_position(32'h8000_0000, 32'hFFFF_FFFF);
      drain_steps();
   endtask

   // Flat segment along x, with minor crossings, wraps and arrival.
   task automatic test_x_major();
      set_segment(32'h0000_0000, 32'h0000_0000, 32'h000A_0000, 32'h0003_0000,
                  32'd6553600);
      send_position(32'h0000_0000, 32'h0000_0000);
      send_position(32'h0002_8000, 32'h0000_F000);
      send_position(32'hFFFE_C000, 32'hFFFF_8000);
      send_position(32'h7FFF_8000, 32'h7FFF_FFFF);
      send_position(32'h000A_4000, 32'h0003_1000);
      send_position(32'hFFFF_0000, 32'h8000_0000);
      drain_steps();
      // Equal absolute distances keep x as the major axis.
      set_segment(32'h0000_0000, 32'h0000_0000, 32'h0005_0000, 32'hFFFB_0000,
                  32'd6553600);
      send_position(32'h0001_4000, 32'hFFFF_C000);
      send_position(32'h0000_0000, 32'h0000_0000);
      drain_steps();
   endtask

   // Steep segment along y, negative minor distance.
   task automatic test_y_major();
      set_segment(32'h0001_0000, 32'h0000_0000, 32'hFFFE_0000, 32'h000C_0000,
                  32'd6553600);
      send_position(32'h0000_8000, 32'h0003_4000);
      send_position(32'hFFFF_0001, 32'hFFFF_FFFF);
      send_position(32'hFFFE_8000, 32'h000C_8000);
      drain_steps();
      // Both distances negative: the segment counts as not moving.
      set_segment(32'h0000_0000, 32'h0000_0000, 32'hFFF6_0000, 32'hFFFD_0000,
                  32'd6553600);
      send_position(32'h0004_2000, 32'h0001_3000);
      drain_steps();
   endtask

   // No motion, crawling speed that saturates, top speed, full-range segment.
   task automatic test_speed_extremes();
      set_segment(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h0002_0000,
                  32'd0);
      send_position(32'h0001_8000, 32'h0000_8000);
      drain_steps();
      write_csr(CSR_SPEED, 32'd1);
      send_position(32'h0001_8000, 32'h0000_8000);
      send_position(32'h8000_0000, 32'h7FFF_FFFF);
      drain_steps();
      write_csr(CSR_SPEED, 32'hFFFF_FFFF);
      send_position(32'h0001_8000, 32'h0000_8000);
      send_position(32'h7FFF_FFFF, 32'h8000_0000);
      drain_steps();
   endtask

   // A write to an index beyond the register file changes nothing.
   task automatic test_unused_index();
      write_csr(CSR_UNUSED, 32'h0000_0000);
      send_position(32'h0003_3333, 32'h0000_1111);
      drain_steps();
   endtask

   function automatic logic [31:0] small_coord();
      return $urandom_range(0, 1) ? {$urandom} % 32'h0028_0000 - 32'h0014_0000
                                  : ($urandom_range(0, 40) - 20) << FRAC;
   endfunction

   // Random segments and positions, half of them near the segment's start or end.
   task automatic test_random_walk();
      int done_items = 0;
      int n;
      logic [31:0] x, y, spd;
      while (done_items < RAND_ITEMS) begin
         case ($urandom_range(3))
            0: spd = $urandom_range(0, 1) ? 32'd0
                     : ($urandom_range(0, 1) ? 32'd1 : 32'hFFFF_FFFF);
            1: spd = $urandom;
            default: spd = $urandom_range(1, 32'h0100_0000);
         endcase
         if ($urandom_range(3) == 0)
            set_segment($urandom, $urandom, $urandom, $urandom, spd);
         else
            set_segment(small_coord(), small_coord(), small_coord(), small_coord(), spd);
         for (n = 0; n < PHASE_ITEMS && done_items < RAND_ITEMS; n++) begin
            case ($urandom_range(9))
               0, 1, 2: begin
                  x = seg_start_x + ({$urandom} % 32'h0010_0000) - 32'h0008_0000;
                  y = seg_start_y + ({$urandom} % 32'h0010_0000) - 32'h0008_0000;
               end
               3, 4: begin
                  x = seg_end_x + ({$urandom} % 32'h0002_0000) - 32'h0001_0000;
                  y = seg_end_y + ({$urandom} % 32'h0002_0000) - 32'h0001_0000;
               end
               5: begin
                  x = small_coord() & 32'hFFFF_0000;
                  y = small_coord();
               end
               6: begin
                  x = small_coord();
                  y = small_coord();
               end
               default: begin
                  x = $urandom;
                  y = $urandom;
               end
            endcase
            send_position(x, y);
            done_items++;
         end
         drain_steps();
      end
   endtask

   initial begin
      seg_start_x = '0;
      seg_start_y = '0;
      seg_end_x = '0;
      seg_end_y = '0;
      move_speed = SPEED_RESET;
      burst_left = $urandom_range(1, 60);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_segment();
      test_x_major();
      test_y_major();
      test_speed_extremes();
      test_unused_index();
      test_random_walk();

      drain_steps();
      repeat (LATENCY + 20) @(posedge clock);
      $display("Sent %0d positions and checked %0d steps over directed and random segments.",
               steps_sent, steps_checked);
      $display("Saw %0d saturated step times and %0d arrivals at the end point.",
               overflow_seen, arrival_seen);
      if (mismatch_count == 0 && pending_steps.size() == 0) begin
         $display("line_grid_crossing_stepper_test: done, clean");
      end else begin
         $display("line_grid_crossing_stepper_test: done, errors");
      end
      $finish;
   end

endmodule
